// File: src/ggc_pkg.sv
// Shared widths and default parameters of the greedy graph coloring core.
package ggc_pkg;

  // Field widths of the transfer payloads.
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned COLOUR_W = 6;
  localparam int unsigned COUNT_W  = 7;

  // Default sizes of the color store and of the color set.
  localparam int unsigned MAX_POINTS_DEF  = 1024;
  localparam int unsigned MAX_COLOURS_DEF = 64;

endpackage

// File: src/ggc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module ggc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data register holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/greedy_graph_colouring_core.sv
// Top level of the first-fit greedy graph coloring core.
// The core takes one neighbor transfer per clock cycle and gives one result for each
// point: the transfer that carries last_of_point passes the lookup stage register and
// then the result register. A transfer looks up the neighbor's color in the color store
// (registered read); the color written by the point just finished is forwarded, so a
// neighbor written in the cycle of its read is seen at once. The input stalls only while
// a finished result waits in the output register and the next point also ends. There is
// no clearing pass after reset: only already colored points are ever looked up.
module greedy_graph_colouring_core
  #(
  parameter int unsigned MAX_POINTS  = ggc_pkg::MAX_POINTS_DEF,
  parameter int unsigned MAX_COLOURS = ggc_pkg::MAX_COLOURS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ggc_pkg::IDX_W-1:0]    in_neighbour_index,
  input  logic                         in_neighbour_valid,
  input  logic                         in_last_of_point,
  input  logic                         in_new_graph,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ggc_pkg::IDX_W-1:0]    out_point_index,
  output logic [ggc_pkg::COLOUR_W-1:0] out_point_colour,
  output logic [ggc_pkg::COUNT_W-1:0]  out_colour_count,
  output logic                         out_overflow
);
  import ggc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned EW = (AW > IDX_W) ? AW : IDX_W;

  // Point counter of the accept stage.
  logic [AW-1:0] cur_point_r, cur_point_nxt;
  logic [AW-1:0] acc_point;
  logic          acc_hit;
  logic          in_xfer;

  // Lookup stage registers.
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_hit_r, s1_last_r, s1_fresh_r;
  logic [AW-1:0] s1_point_r, s1_addr_r;
  logic          s1_adv, s1_fire;

  // Accumulated state of the current point and graph.
  logic [MAX_COLOURS-1:0] mask_r, mask_nxt;
  logic [COUNT_W-1:0]     colours_r, colours_nxt;

  // Forwarding of the most recent store write.
  logic                fwd_valid_r;
  logic [AW-1:0]       fwd_addr_r;
  logic [COLOUR_W-1:0] fwd_colour_r;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    out_index_r;
  logic [COLOUR_W-1:0] out_colour_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_ovf_r;

  // Stage one datapath.
  logic [COLOUR_W-1:0]    ram_rdata;
  logic [COLOUR_W-1:0]    nb_colour;
  logic [MAX_COLOURS-1:0] mask_base, mask_cur, free_vec;
  logic [COUNT_W-1:0]     cnt_base, cnt_new;
  logic [COLOUR_W-1:0]    sel_colour, pick_colour;
  logic                   found, ovf;

  // Handshake: stage one moves on unless a result must wait for a full output slot.
  assign s1_adv   = !s1_last_r || !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  // Accept stage: a new graph restarts at point zero; only colored points are looked up.
  always_comb begin
    acc_point = in_new_graph ? '0 : cur_point_r;
    acc_hit   = in_neighbour_valid && (EW'(in_neighbour_index) < EW'(acc_point));
    cur_point_nxt = cur_point_r;
    if (in_xfer) begin
      if (in_last_of_point) begin
        cur_point_nxt = (acc_point == AW'(MAX_POINTS - 1)) ? '0 : acc_point + AW'(1);
      end else begin
        cur_point_nxt = acc_point;
      end
    end
  end

  // Stage one valid bit.
  always_comb begin
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  ggc_ram #(
    .WIDTH(COLOUR_W),
    .DEPTH(MAX_POINTS)
  ) u_colour_store (
    .clk   (clk),
    .we    (s1_fire && s1_last_r),
    .waddr (s1_point_r),
    .wdata (pick_colour),
    .re    (in_xfer),
    .raddr (AW'(EW'(in_neighbour_index))),
    .rdata (ram_rdata)
  );

  // Neighbor color, taking the last write when the store read missed it.
  assign nb_colour = (fwd_valid_r && (fwd_addr_r == s1_addr_r)) ? fwd_colour_r : ram_rdata;

  // Mark the neighbor's color as used.
  always_comb begin
    mask_base = s1_fresh_r ? '0 : mask_r;
    cnt_base  = s1_fresh_r ? '0 : colours_r;
    mask_cur  = mask_base;
    if (s1_hit_r) begin
      mask_cur = mask_base | (MAX_COLOURS'(1) << nb_colour);
    end
  end

  // First fit: lowest color already opened that no neighbor uses.
  always_comb begin
    sel_colour = '0;
    for (int k = 0; k < MAX_COLOURS; k++) begin
      free_vec[k] = !mask_cur[k] && (COUNT_W'(k) < cnt_base);
    end
    for (int k = MAX_COLOURS - 1; k >= 0; k--) begin
      if (free_vec[k]) begin
        sel_colour = COLOUR_W'(k);
      end
    end
    found = |free_vec;
  end

  // Open a new color, or saturate at the top color.
  always_comb begin
    ovf     = 1'b0;
    cnt_new = cnt_base;
    if (found) begin
      pick_colour = sel_colour;
    end else if (cnt_base < COUNT_W'(MAX_COLOURS)) begin
      pick_colour = COLOUR_W'(cnt_base);
      cnt_new     = cnt_base + COUNT_W'(1);
    end else begin
      pick_colour = COLOUR_W'(MAX_COLOURS - 1);
      ovf         = 1'b1;
    end
  end

  // Next mask and color count.
  always_comb begin
    mask_nxt    = mask_r;
    colours_nxt = colours_r;
    if (s1_fire) begin
      if (s1_last_r) begin
        mask_nxt    = '0;
        colours_nxt = cnt_new;
      end else begin
        mask_nxt    = mask_cur;
        colours_nxt = cnt_base;
      end
    end
  end

  // Result register valid bit.
  always_comb begin
    if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_point_r <= '0;
      s1_valid_r  <= 1'b0;
      mask_r      <= '0;
      colours_r   <= '0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_point_r <= cur_point_nxt;
      s1_valid_r  <= s1_valid_nxt;
      mask_r      <= mask_nxt;
      colours_r   <= colours_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire && s1_last_r) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_hit_r   <= acc_hit;
      s1_last_r  <= in_last_of_point;
      s1_fresh_r <= in_new_graph;
      s1_point_r <= acc_point;
      s1_addr_r  <= AW'(EW'(in_neighbour_index));
    end
    if (s1_fire && s1_last_r) begin
      fwd_addr_r   <= s1_point_r;
      fwd_colour_r <= pick_colour;
      out_index_r  <= IDX_W'(s1_point_r);
      out_colour_r <= pick_colour;
      out_count_r  <= cnt_new;
      out_ovf_r    <= ovf;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_point_index  = out_index_r;
  assign out_point_colour = out_colour_r;
  assign out_colour_count = out_count_r;
  assign out_overflow     = out_ovf_r;

  // A stalled lookup stage must hold off the input.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |-> !in_ready)
    else $error("input accepted while lookup stage is stalled");

  // The color count never exceeds the color limit.
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r <= COUNT_W'(MAX_COLOURS)))
    else $error("color count above limit");

  // Overflow only with every color open, and then the top color is given.
  a_overflow_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |->
      (out_count_r == COUNT_W'(MAX_COLOURS) && out_colour_r == COLOUR_W'(MAX_COLOURS - 1)))
    else $error("overflow result not saturated");

  // Without overflow the given color is one of the opened colors.
  a_colour_opened: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ovf_r) |-> (COUNT_W'(out_colour_r) < out_count_r))
    else $error("color given that was never opened");

endmodule
